>>> design/xml_char_reference_decoder_assert.svh
// assertion macros for the xml character reference decoder
// used by the checker module, no other dependencies
`ifndef XML_CHAR_REFERENCE_DECODER_ASSERT_SVH
`define XML_CHAR_REFERENCE_DECODER_ASSERT_SVH

// property that must hold on every clock outside reset
`define XCR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define XCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/xcr_pkg.sv
// package for the xml character reference decoder
// types and constants shared by controller, datapath and top level
package xcr_pkg;
    localparam int unsigned RefWindow = 12;
    localparam int unsigned HeldDepth = RefWindow + 1;
    localparam int unsigned CntW = $clog2(HeldDepth + 1);
    localparam int unsigned IdxW = $clog2(HeldDepth);
    localparam logic [20:0] CpLimit = 21'h110000;

    localparam logic [7:0] ChAmp  = 8'h26;
    localparam logic [7:0] ChSemi = 8'h3b;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INPUT,
        S_RESOLVE,
        S_EMIT,
        S_SCAN,
        S_FLUSH,
        S_END
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load_in;     // latch the accepted byte
        logic hold_clear;  // held_count := 0
        logic hold_push;   // push a byte to the window
        logic push_sel;    // 0 input byte, 1 scan byte
        logic res_clear;   // clear result queue
        logic res_pass;    // queue the input byte
        logic res_amp;     // queue an ampersand
        logic res_scan;    // queue the scan byte
        logic res_held;    // queue held byte at flush index
        logic res_semi;    // queue a semicolon
        logic resolve_go;  // start resolving the window
        logic scan_start;  // copy window to replay buffer
        logic scan_step;   // advance replay index
        logic flush_start;
        logic flush_step;
        logic pop;         // result taken
    } t_cmd;

    typedef struct packed {
        logic       in_ref;
        logic [CntW-1:0] held_count;
        logic       is_amp;
        logic       is_semi;
        logic       last;
        logic       resolve_done;
        logic       resolve_lit;   // name passes through literally
        logic       scan_more;
        logic       scan_is_amp;
        logic       flush_more;
        logic       res_one;       // exactly one queued result left
    } t_stat;

    function automatic logic [4:0] f_digit(input logic [7:0] c, input logic hex);
        logic [4:0] d;
        d = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) d = 5'(c - 8'h30);
        else if (hex && c >= 8'h61 && c <= 8'h66) d = 5'(c - 8'h57);
        else if (hex && c >= 8'h41 && c <= 8'h46) d = 5'(c - 8'h37);
        return d;
    endfunction
endpackage

>>> design/xcr_if.sv
// valid/ready channel interface for the decoder
// depends on nothing
interface xcr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;
    modport source(output valid, output in_byte, output in_last, input ready);
    modport sink(input valid, input in_byte, input in_last, output ready);
endinterface

interface xcr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       out_last;
    modport source(output valid, output out_byte, output has_byte, output out_last,
                   input ready);
    modport sink(input valid, input out_byte, input has_byte, input out_last,
                 output ready);
endinterface

>>> design/xcr_datapath.sv
// datapath: held window, replay buffer, numeric resolver and result queue
// depends on xcr_pkg
module xcr_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  xcr_pkg::t_cmd  i_cmd,
    input  logic [7:0]     i_byte,
    input  logic           i_last,
    output xcr_pkg::t_stat o_stat,
    output logic [7:0]     o_res_byte,
    output logic           o_res_has,
    output logic           o_res_valid,
    input  logic           i_mark_last
);
    import xcr_pkg::*;

    localparam int unsigned QDepth = 16;

    logic [7:0] r_held [HeldDepth];
    logic [CntW-1:0] r_cnt, n_cnt;
    logic [7:0] r_byte;
    logic r_last;

    // replay buffer for window overflow
    logic [7:0] r_rep [HeldDepth];
    logic [CntW-1:0] r_rep_n, r_rep_i;
    logic [CntW-1:0] r_fl_i;

    // resolver
    logic r_rbusy, r_rdone, r_rlit, r_hex;
    logic [CntW-1:0] r_ri;
    logic [20:0] r_val;
    logic r_stop;

    // result queue
    logic [7:0] r_q [QDepth];
    logic [4:0] r_qn, r_qh;
    logic r_qlast;

    logic [7:0] w_scan, w_push, w_flush;
    logic [CntW-1:0] w_len;
    logic w_lt, w_gt, w_amp, w_quot, w_apos, w_num;
    logic [4:0] w_dig;
    logic [25:0] w_acc;

    assign w_scan  = r_rep[r_rep_i[IdxW-1:0]];
    assign w_flush = r_held[r_fl_i[IdxW-1:0]];
    assign w_push  = i_cmd.push_sel ? w_scan : r_byte;
    assign w_len   = r_cnt - CntW'(1);

    assign w_lt   = w_len == CntW'(2) && r_held[1] == "l" && r_held[2] == "t";
    assign w_gt   = w_len == CntW'(2) && r_held[1] == "g" && r_held[2] == "t";
    assign w_amp  = w_len == CntW'(3) && r_held[1] == "a" && r_held[2] == "m"
                    && r_held[3] == "p";
    assign w_quot = w_len == CntW'(4) && r_held[1] == "q" && r_held[2] == "u"
                    && r_held[3] == "o" && r_held[4] == "t";
    assign w_apos = w_len == CntW'(4) && r_held[1] == "a" && r_held[2] == "p"
                    && r_held[3] == "o" && r_held[4] == "s";
    assign w_num  = w_len > CntW'(1) && r_held[1] == "#";

    assign w_dig = f_digit(r_held[r_ri[IdxW-1:0]], r_hex);
    assign w_acc = r_hex ? {r_val, 4'h0} + 26'(w_dig[3:0])
                         : 26'(r_val) * 26'd10 + 26'(w_dig[3:0]);

    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.hold_clear) n_cnt = '0;
        if (i_cmd.hold_push) n_cnt = n_cnt + CntW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_byte <= i_byte;
            r_last <= i_last;
        end
        if (i_cmd.hold_push) r_held[(i_cmd.hold_clear ? IdxW'(0) : r_cnt[IdxW-1:0])] <= w_push;
        if (i_cmd.scan_start) begin
            for (int k = 0; k < RefWindow; k++) r_rep[k] <= r_held[k+1];
            r_rep[r_cnt[IdxW-1:0] - IdxW'(1)] <= r_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rep_n <= '0;
            r_rep_i <= '0;
            r_fl_i <= '0;
            r_rbusy <= 1'b0;
            r_rdone <= 1'b0;
            r_rlit <= 1'b0;
            r_qn <= '0;
            r_qh <= '0;
            r_qlast <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (i_cmd.scan_start) begin
                r_rep_n <= r_cnt;
                r_rep_i <= '0;
            end else if (i_cmd.scan_step) begin
                r_rep_i <= r_rep_i + CntW'(1);
            end
            if (i_cmd.flush_start) r_fl_i <= '0;
            else if (i_cmd.flush_step) r_fl_i <= r_fl_i + CntW'(1);

            // resolver: one digit per cycle
            r_rdone <= 1'b0;
            if (i_cmd.resolve_go) begin
                r_rlit <= 1'b0;
                r_val <= '0;
                r_stop <= 1'b0;
                if (w_lt || w_gt || w_amp || w_quot || w_apos || !w_num) begin
                    r_rdone <= 1'b1;
                    r_rlit <= !(w_lt || w_gt || w_amp || w_quot || w_apos);
                    r_hex <= 1'b0;
                end else begin
                    r_rbusy <= 1'b1;
                    r_hex <= r_held[2] == "x" || r_held[2] == "X";
                    r_ri <= (r_held[2] == "x" || r_held[2] == "X") ? CntW'(3) : CntW'(2);
                end
            end else if (r_rbusy) begin
                if (r_stop || r_ri >= r_cnt || w_dig[4]) begin
                    r_rbusy <= 1'b0;
                    r_rdone <= 1'b1;
                end else begin
                    r_val <= (w_acc >= 26'(CpLimit)) ? CpLimit : w_acc[20:0];
                    r_ri <= r_ri + CntW'(1);
                end
            end

            // result queue
            if (i_cmd.res_clear) begin
                r_qn <= '0;
                r_qh <= '0;
                r_qlast <= 1'b0;
            end else begin
                if (i_cmd.pop) r_qh <= r_qh + 5'd1;
                if (i_mark_last) r_qlast <= 1'b1;
                if (r_qn < 5'(QDepth)) begin
                    if (i_cmd.res_pass) begin
                        r_q[r_qn[3:0]] <= r_byte; r_qn <= r_qn + 5'd1;
                    end else if (i_cmd.res_amp) begin
                        r_q[r_qn[3:0]] <= ChAmp; r_qn <= r_qn + 5'd1;
                    end else if (i_cmd.res_scan) begin
                        r_q[r_qn[3:0]] <= w_scan; r_qn <= r_qn + 5'd1;
                    end else if (i_cmd.res_held) begin
                        r_q[r_qn[3:0]] <= w_flush; r_qn <= r_qn + 5'd1;
                    end else if (i_cmd.res_semi) begin
                        r_q[r_qn[3:0]] <= ChSemi; r_qn <= r_qn + 5'd1;
                    end
                end
            end
            // named and numeric results
            if (r_rdone && !r_rlit && !i_cmd.res_clear) begin
                if (w_lt) begin r_q[0] <= 8'h3c; r_qn <= 5'd1; end
                else if (w_gt) begin r_q[0] <= 8'h3e; r_qn <= 5'd1; end
                else if (w_amp) begin r_q[0] <= 8'h26; r_qn <= 5'd1; end
                else if (w_quot) begin r_q[0] <= 8'h22; r_qn <= 5'd1; end
                else if (w_apos) begin r_q[0] <= 8'h27; r_qn <= 5'd1; end
                else if (r_val == '0 || r_val >= CpLimit) r_qn <= 5'd0;
                else if (r_val < 21'h80) begin
                    r_q[0] <= 8'(r_val); r_qn <= 5'd1;
                end else if (r_val < 21'h800) begin
                    r_q[0] <= 8'hc0 | 8'(r_val >> 6);
                    r_q[1] <= 8'h80 | {2'b0, r_val[5:0]};
                    r_qn <= 5'd2;
                end else if (r_val < 21'h10000) begin
                    r_q[0] <= 8'he0 | 8'(r_val >> 12);
                    r_q[1] <= 8'h80 | {2'b0, r_val[11:6]};
                    r_q[2] <= 8'h80 | {2'b0, r_val[5:0]};
                    r_qn <= 5'd3;
                end else begin
                    r_q[0] <= 8'hf0 | 8'(r_val >> 18);
                    r_q[1] <= 8'h80 | {2'b0, r_val[17:12]};
                    r_q[2] <= 8'h80 | {2'b0, r_val[11:6]};
                    r_q[3] <= 8'h80 | {2'b0, r_val[5:0]};
                    r_qn <= 5'd4;
                end
            end
        end
    end

    // bare end marker shows as soon as the controller marks the last byte
    assign o_res_valid = (r_qh < r_qn)
                         || ((r_qlast || i_mark_last) && r_qn == '0 && r_qh == '0);
    assign o_res_has   = r_qn != '0;
    assign o_res_byte  = r_qn != '0 ? r_q[r_qh[3:0]] : 8'h00;

    always_comb begin
        o_stat.in_ref       = r_cnt != '0;
        o_stat.held_count   = r_cnt;
        o_stat.is_amp       = r_byte == ChAmp;
        o_stat.is_semi      = r_byte == ChSemi;
        o_stat.last         = r_last;
        o_stat.resolve_done = r_rdone;
        o_stat.resolve_lit  = r_rlit;
        o_stat.scan_more    = r_rep_i < r_rep_n;
        o_stat.scan_is_amp  = w_scan == ChAmp;
        o_stat.flush_more   = r_fl_i < r_cnt;
        o_stat.res_one      = (r_qh + 5'd1) == r_qn;
    end
endmodule

>>> design/xcr_ctrl.sv
// controller state machine for the decoder
// depends on xcr_pkg
module xcr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    input  logic           i_out_valid,
    input  logic           i_out_tail,
    input  xcr_pkg::t_stat i_stat,
    output xcr_pkg::t_cmd  o_cmd,
    output logic           o_mark_last,
    output logic           o_out_last
);
    import xcr_pkg::*;

    t_state r_state, n_state;
    logic   r_lit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lit <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_RESOLVE && i_stat.resolve_done) r_lit <= i_stat.resolve_lit;
            else if (r_state == S_IDLE) r_lit <= 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_INPUT;
            S_INPUT: begin
                if (!i_stat.in_ref) n_state = S_END;
                else if (i_stat.is_semi) n_state = S_RESOLVE;
                else if (i_stat.held_count >= CntW'(RefWindow)) n_state = S_SCAN;
                else n_state = S_END;
            end
            S_RESOLVE: if (i_stat.resolve_done)
                n_state = i_stat.resolve_lit ? S_FLUSH : S_END;
            S_SCAN:  if (!i_stat.scan_more) n_state = S_END;
            S_FLUSH: if (!i_stat.flush_more) n_state = S_END;
            S_END: begin
                if (i_stat.last && i_stat.in_ref && !r_lit) n_state = S_FLUSH;
                else if (!i_out_valid) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_mark_last = 1'b0;
        o_out_last = 1'b0;
        o_cmd.pop = i_out_valid && i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load_in = i_in_valid;
                o_cmd.res_clear = 1'b1;
                o_cmd.pop = 1'b0;
            end
            S_INPUT: begin
                if (!i_stat.in_ref) begin
                    if (i_stat.is_amp) o_cmd.hold_push = 1'b1;
                    else o_cmd.res_pass = 1'b1;
                end else if (i_stat.is_semi) begin
                    o_cmd.resolve_go = 1'b1;
                end else if (i_stat.held_count >= CntW'(RefWindow)) begin
                    // window closes; the rescan starts with no reference open
                    o_cmd.scan_start = 1'b1;
                    o_cmd.res_amp = 1'b1;
                    o_cmd.hold_clear = 1'b1;
                end else begin
                    o_cmd.hold_push = 1'b1;
                end
            end
            S_RESOLVE: begin
                if (i_stat.resolve_done) begin
                    o_cmd.flush_start = 1'b1;
                    if (!i_stat.resolve_lit) o_cmd.hold_clear = 1'b1;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_more) begin
                    o_cmd.scan_step = 1'b1;
                    if (i_stat.held_count == '0 && i_stat.scan_is_amp) begin
                        o_cmd.hold_push = 1'b1;
                        o_cmd.push_sel = 1'b1;
                    end else if (i_stat.held_count == '0 || i_stat.held_count
                                 == CntW'(RefWindow+1)) begin
                        o_cmd.res_scan = 1'b1;
                        o_cmd.hold_clear = i_stat.held_count != '0;
                    end else begin
                        o_cmd.hold_push = 1'b1;
                        o_cmd.push_sel = 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                if (i_stat.flush_more) begin
                    o_cmd.flush_step = 1'b1;
                    o_cmd.res_held = 1'b1;
                end else begin
                    o_cmd.res_semi = r_lit;
                    o_cmd.hold_clear = 1'b1;
                end
            end
            S_END: begin
                if (i_stat.last && i_stat.in_ref && !r_lit) begin
                    o_cmd.flush_start = 1'b1;
                    o_cmd.pop = 1'b0;
                end else begin
                    o_mark_last = i_stat.last;
                    o_out_last = i_stat.last && i_out_tail;
                end
            end
            default: ;
        endcase
    end
endmodule

>>> design/xml_char_reference_decoder.sv
// channel     | dir | payload
// in          | in  | in_byte[7:0], in_last
// out         | out | out_byte[7:0], has_byte, out_last
//
// each byte passes through accept, decode and end, and its results leave from the queue;
// a named reference adds a resolve step, a numeric one resolves digit by digit, a
// literal name flushes its held bytes and a semicolon, an end-of-text flush sends the
// held bytes, and an overflow rescans the window.
// reset is synchronous active low and clears the window count and the fsm.
// a stalled output holds the block in its end state; no new byte is taken.
module xml_char_reference_decoder (
    input  logic i_clk,
    input  logic i_rst_n,
    xcr_in_if.sink    i_in,
    xcr_out_if.source o_out
);
    import xcr_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic [7:0] w_rbyte;
    logic w_rhas, w_rvalid, w_mark, w_olast, w_ovalid, w_tail;

    // controller sequences one byte at a time
    xcr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_out_ready(o_out.ready),
        .i_out_valid(w_ovalid),
        .i_out_tail (w_tail),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_mark_last(w_mark),
        .o_out_last (w_olast)
    );

    // window, resolver and result queue
    xcr_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_byte     (i_in.in_byte),
        .i_last     (i_in.in_last),
        .o_stat     (w_stat),
        .o_res_byte (w_rbyte),
        .o_res_has  (w_rhas),
        .o_res_valid(w_rvalid),
        .i_mark_last(w_mark)
    );

    // results of the final byte only leave from the end state, after all are queued
    assign w_ovalid = w_rvalid && (w_mark || !w_stat.last);
    // tail: one result left, or the bare end marker
    assign w_tail = !w_rhas || w_stat.res_one;
    assign o_out.valid    = w_ovalid;
    assign o_out.out_byte = w_rbyte;
    assign o_out.has_byte = w_rhas;
    assign o_out.out_last = w_olast && w_tail;
endmodule

>>> design/xcr_checker.sv
// port-level checker for the decoder, bound to the top level
// depends on the assertion macro header
`include "xml_char_reference_decoder_assert.svh"
module xcr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       has_byte
);
    `XCR_ASSERT(a_bare_zero, i_clk, i_rst_n, !(out_valid && !has_byte) || out_byte == 8'h00)
    `XCR_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, in_valid && in_ready, !in_ready)
    `XCR_ASSERT(a_no_overlap, i_clk, i_rst_n, !(in_ready && out_valid))
endmodule

bind xml_char_reference_decoder xcr_checker u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .in_valid (i_in.valid),
    .in_ready (i_in.ready),
    .out_valid(o_out.valid),
    .out_ready(o_out.ready),
    .out_byte (o_out.out_byte),
    .has_byte (o_out.has_byte)
);

>>> verif/xcr_tb_pkg.sv
// shared constants for the decoder testbench
// depends on nothing
package xcr_tb_pkg;
    localparam int unsigned WindowLen = 12;
    localparam int unsigned MaxOut = 16;
    localparam logic [20:0] CodeLimit = 21'h110000;
endpackage

>>> verif/testbench.sv
// self-checking testbench for xml_char_reference_decoder
// depends on xcr_if.sv, xcr_tb_pkg and the decoder top level
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import xcr_tb_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       last;
    } t_out_item;

    logic i_clk;
    logic i_rst_n;
    xcr_in_if  in_ch ();
    xcr_out_if out_ch ();

    xml_char_reference_decoder dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // predictor state
    logic [7:0]  win_bytes [0:WindowLen];
    int unsigned win_count;
    logic        win_open;

    t_out_item decoded_q [$];
    t_out_item step_out [$];

    int unsigned n_fail;
    int unsigned n_sent;
    int unsigned n_got;
    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;
    int unsigned hold_off;
    int unsigned idle_cycles;

    function automatic void push_byte(input logic [7:0] b);
        t_out_item it;
        if (step_out.size() >= MaxOut) return;
        it.data = b;
        it.has = 1'b1;
        it.last = 1'b0;
        step_out.push_back(it);
    endfunction

    function automatic void push_code(input logic [20:0] cp);
        if (cp < 21'h80) begin
            push_byte(cp[7:0]);
        end else if (cp < 21'h800) begin
            push_byte(8'hC0 | 8'(cp >> 6));
            push_byte(8'h80 | 8'(cp & 21'h3f));
        end else if (cp < 21'h10000) begin
            push_byte(8'hE0 | 8'(cp >> 12));
            push_byte(8'h80 | 8'((cp >> 6) & 21'h3f));
            push_byte(8'h80 | 8'(cp & 21'h3f));
        end else begin
            push_byte(8'hF0 | 8'(cp >> 18));
            push_byte(8'h80 | 8'((cp >> 12) & 21'h3f));
            push_byte(8'h80 | 8'((cp >> 6) & 21'h3f));
            push_byte(8'h80 | 8'(cp & 21'h3f));
        end
    endfunction

    function automatic bit name_eq(input string w);
        if (win_count - 1 != w.len()) return 0;
        for (int i = 0; i < w.len(); i++)
            if (win_bytes[i + 1] != w[i]) return 0;
        return 1;
    endfunction

    function automatic int hex_digit(input logic [7:0] c, input bit hex);
        if (c >= "0" && c <= "9") return c - "0";
        if (hex && c >= "a" && c <= "f") return c - "a" + 10;
        if (hex && c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    // resolve a window closed by a semicolon
    function automatic void resolve_name();
        int unsigned len;
        bit hex;
        int d;
        logic [31:0] v;
        len = win_count - 1;
        if (name_eq("lt")) push_byte("<");
        else if (name_eq("gt")) push_byte(">");
        else if (name_eq("amp")) push_byte("&");
        else if (name_eq("quot")) push_byte("\"");
        else if (name_eq("apos")) push_byte("'");
        else if (len > 1 && win_bytes[1] == "#") begin
            hex = (win_bytes[2] == "x" || win_bytes[2] == "X");
            v = 0;
            for (int k = hex ? 2 : 1; k < len; k++) begin
                d = hex_digit(win_bytes[k + 1], hex);
                if (d < 0) break;
                v = v * (hex ? 16 : 10) + d;
                if (v >= CodeLimit) v = CodeLimit;
            end
            if (v != 0 && v < CodeLimit) push_code(v[20:0]);
        end else begin
            for (int k = 0; k < win_count; k++) push_byte(win_bytes[k]);
            push_byte(";");
        end
    endfunction

    function automatic void predict_decode(input logic [7:0] b, input logic last);
        logic [7:0] replay [$];
        t_out_item it;
        step_out.delete();
        if (!win_open) begin
            if (b == "&") begin
                win_bytes[0] = b;
                win_count = 1;
                win_open = 1'b1;
            end else begin
                push_byte(b);
            end
        end else if (b == ";") begin
            resolve_name();
            win_count = 0;
            win_open = 1'b0;
        end else if (win_count >= WindowLen) begin
            // window full: ampersand out, rest rescanned
            for (int k = 1; k < win_count; k++) replay.push_back(win_bytes[k]);
            replay.push_back(b);
            push_byte("&");
            win_count = 0;
            win_open = 1'b0;
            foreach (replay[k]) begin
                if (win_open) begin
                    win_bytes[win_count] = replay[k];
                    win_count++;
                end else if (replay[k] == "&") begin
                    win_bytes[0] = "&";
                    win_count = 1;
                    win_open = 1'b1;
                end else begin
                    push_byte(replay[k]);
                end
            end
        end else begin
            win_bytes[win_count] = b;
            win_count++;
        end
        if (last) begin
            if (win_open) begin
                for (int k = 0; k < win_count; k++) push_byte(win_bytes[k]);
                win_count = 0;
                win_open = 1'b0;
            end
            if (step_out.size() == 0) begin
                it.data = 8'h00;
                it.has = 1'b0;
                it.last = 1'b1;
                step_out.push_back(it);
            end else begin
                step_out[step_out.size() - 1].last = 1'b1;
            end
        end
        foreach (step_out[k]) decoded_q.push_back(step_out[k]);
    endfunction

    initial begin
        in_ch.valid = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.in_last = 1'b0;
        out_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        win_count = 0;
        win_open = 1'b0;
        n_fail = 0;
        n_sent = 0;
        n_got = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        hold_off = 0;
        idle_cycles = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // receiver: random stall plus an optional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_off != 0) begin
            out_ch.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_item exp_it;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_got++;
            if (decoded_q.size() == 0) begin
                $error("unexpected transfer byte=%h has=%b last=%b",
                       out_ch.out_byte, out_ch.has_byte, out_ch.out_last);
                n_fail++;
            end else begin
                exp_it = decoded_q.pop_front();
                if (out_ch.out_byte !== exp_it.data) begin
                    $error("out_byte expected %h actual %h", exp_it.data, out_ch.out_byte);
                    n_fail++;
                end
                if (out_ch.has_byte !== exp_it.has) begin
                    $error("has_byte expected %b actual %b", exp_it.has, out_ch.has_byte);
                    n_fail++;
                end
                if (out_ch.out_last !== exp_it.last) begin
                    $error("out_last expected %b actual %b", exp_it.last, out_ch.out_last);
                    n_fail++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // send one byte, with random idle before it
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_last <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_decode(b, last);
        n_sent++;
    endtask

    task automatic send_text(input string s, input bit last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], last && (i == s.len() - 1));
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_name_byte();
        case ($urandom_range(9))
            0: return "&";
            1: return ";";
            2: return "#";
            3: return "x";
            4, 5: return 8'("0") + 8'($urandom_range(9));
            6: return 8'("a") + 8'($urandom_range(5));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic test_directed();
        send_text("a&lt;&gt;&amp;&quot;&apos;", 0);
        send_text("&#65;&#x7FF;&#XFFFF;&#x10FFFF;&#x110000;&#0;", 0);
        send_text("&#99999999;&#;&#x;&#12a;&foo;", 0);
        send_text("&abcdefghijklmnop&q;", 0);
        send_byte(8'h00, 0);
        send_byte(8'hFF, 0);
        send_text("&am", 1);
        send_byte("&", 1);
        send_byte(";", 1);
        drain();
    endtask

    // well-formed references with random content, and as often random noise
    task automatic test_random(input int unsigned n_items);
        int unsigned start;
        string s;
        int unsigned len;
        start = n_sent;
        while (n_sent - start < n_items) begin
            case ($urandom_range(7))
                0: send_text("&lt;", 0);
                1: send_text("&amp;", 0);
                2: send_text($sformatf("&#%0d;", $urandom_range(1200000)), 0);
                3: send_text($sformatf("&#x%0h;", $urandom_range(32'h11ffff)), 0);
                4: begin
                    len = $urandom_range(15);
                    send_byte("&", 0);
                    for (int i = 0; i < len; i++) send_byte(rand_name_byte(), 0);
                end
                5: send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
                default: send_byte(rand_name_byte(), $urandom_range(9) == 0);
            endcase
        end
    endtask

    task automatic test_backpressure();
        hold_off <= 300;
        src_idle_pct = 0;
        test_random(40);
        drain();
    endtask

    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        test_directed();
        src_idle_pct = 0;  snk_stall_pct = 0;  test_random(70); drain();
        src_idle_pct = 52; snk_stall_pct = 0;  test_random(55); drain();
        src_idle_pct = 0;  snk_stall_pct = 52; test_random(55); drain();
        src_idle_pct = 26; snk_stall_pct = 26; test_random(55); drain();
        test_backpressure();
        send_byte("x", 1);
        drain();
        $display("covered %0d input bytes and %0d output transfers", n_sent, n_got);
        $display("named and numeric references, window overflow, end of text, stalls");
        if (n_fail == 0 && decoded_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+design
design/xcr_pkg.sv
design/xcr_if.sv
design/xcr_datapath.sv
design/xcr_ctrl.sv
design/xml_char_reference_decoder.sv
design/xcr_checker.sv
verif/xcr_tb_pkg.sv
verif/testbench.sv
